/* hdl/euler_rotation_matrix_unit_defines.svh */
// assertion macros for the euler rotation matrix unit
`ifndef EULER_ROTATION_MATRIX_UNIT_DEFINES_SVH
`define EULER_ROTATION_MATRIX_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS
// property must hold at every clock edge out of reset
`define ERM_ASSERT(label, clk, rstn, prop) \
  label: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("erm assertion failed");
// expression must never be true out of reset
`define ERM_ASSERT_NEVER(label, clk, rstn, expr) \
  label: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
    else $error("erm forbidden condition seen");
`else
`define ERM_ASSERT(label, clk, rstn, prop)
`define ERM_ASSERT_NEVER(label, clk, rstn, expr)
`endif

`endif

/* hdl/erm_pkg.sv */
// shared constants for the euler rotation matrix unit
`timescale 1ns / 1ps
`default_nettype none

package erm_pkg;

  // port widths
  localparam int ANG_IN_W = 16;
  localparam int OUT_W    = 16;
  localparam int OUT_FRAC = 14;
  localparam int OUT_MAX  = 16384;

  // pi/2 in q30
  localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
  localparam logic [31:0] ONE_Q30     = 32'h4000_0000;

  // pipeline depths
  localparam int SC_LAT = 28;
  localparam int MX_LAT = 4;
  localparam int LAT    = SC_LAT + MX_LAT;

endpackage

`default_nettype wire

/* hdl/erm_sincos.sv */
// pipelined sine and cosine of a binary angle, taylor series per quadrant
`timescale 1ns / 1ps
`default_nettype none

module erm_sincos #(
  parameter int ANGLE_BITS = 16,
  parameter int FRAC_BITS  = 14
) (
  input  logic                                clk_i,
  input  logic [erm_pkg::ANG_IN_W-1:0]        angle_i,
  output logic signed [FRAC_BITS+1:0]         sin_o,
  output logic signed [FRAC_BITS+1:0]         cos_o
);
  import erm_pkg::*;

  localparam int RW    = ANGLE_BITS - 2;
  localparam int SW    = FRAC_BITS + 2;
  localparam int QW    = FRAC_BITS + 1;
  localparam int NSTEP = 8;

  localparam logic [1:0] QUAD_0 = 2'd0;
  localparam logic [1:0] QUAD_1 = 2'd1;
  localparam logic [1:0] QUAD_2 = 2'd2;
  localparam logic [1:0] QUAD_3 = 2'd3;

  typedef struct packed {
    logic [31:0] x2;
    logic [1:0]  quad;
  } ctx_t;

  // stage 1: angle to q30 remainder
  logic [ANGLE_BITS-1:0] ang;
  logic [RW+30:0]        th_prod;
  logic [30:0]           th_q;
  logic [1:0]            quad1_q;

  assign ang     = ANGLE_BITS'(angle_i);
  assign th_prod = (RW+31)'(ang[RW-1:0]) * (RW+31)'(HALF_PI_Q30);

  always_ff @(posedge clk_i) begin
    th_q    <= th_prod[RW+30:RW];
    quad1_q <= ang[ANGLE_BITS-1 -: 2];
  end

  // series state at the entry of each step, lane 0 sine, lane 1 cosine
  logic [31:0]        term_q [0:NSTEP][2];
  logic signed [33:0] sum_q  [0:NSTEP][2];
  ctx_t               ctx_q  [0:NSTEP];

  // stage 2: square of the remainder
  logic [61:0] x2_full;
  assign x2_full = 62'(th_q) * 62'(th_q);

  always_ff @(posedge clk_i) begin
    ctx_q[0].x2   <= x2_full[61:30];
    ctx_q[0].quad <= quad1_q;
    term_q[0][0]  <= {1'b0, th_q};
    term_q[0][1]  <= ONE_Q30;
    sum_q[0][0]   <= '0;
    sum_q[0][1]   <= '0;
  end

  logic [31:0]        p_a_q   [NSTEP][2];
  logic signed [33:0] sum_a_q [NSTEP][2];
  ctx_t               ctx_a_q [NSTEP];
  logic [31:0]        p_b_q   [NSTEP][2];
  logic [31:0]        est_b_q [NSTEP][2];
  logic signed [33:0] sum_b_q [NSTEP][2];
  ctx_t               ctx_b_q [NSTEP];

  for (genvar k = 0; k < NSTEP; k++) begin : g_step
    localparam bit ADD = (k % 2) == 0;

    always_ff @(posedge clk_i) begin
      ctx_a_q[k]   <= ctx_q[k];
      ctx_b_q[k]   <= ctx_a_q[k];
      ctx_q[k+1]   <= ctx_b_q[k];
    end

    for (genvar l = 0; l < 2; l++) begin : g_lane
      localparam int          KDIV = (2*k + 2 - l) * (2*k + 3 - l);
      localparam int          SH   = 32 + $clog2(KDIV);
      localparam logic [65:0] MUL  = (66'd1 << SH) / KDIV;

      logic [63:0]        pa;
      logic signed [33:0] tsig;
      logic [65:0]        pb;
      logic [41:0]        qk;
      logic [41:0]        rem;

      assign pa   = 64'(term_q[k][l]) * 64'(ctx_q[k].x2);
      assign tsig = $signed({2'b00, term_q[k][l]});
      assign pb   = 66'(p_a_q[k][l]) * MUL;
      assign qk   = 42'(est_b_q[k][l]) * 42'(KDIV);
      assign rem  = 42'(p_b_q[k][l]) - qk;

      // multiply by x^2, fold the previous term into the sum
      always_ff @(posedge clk_i) begin
        p_a_q[k][l]   <= pa[61:30];
        sum_a_q[k][l] <= ADD ? sum_q[k][l] + tsig : sum_q[k][l] - tsig;
      end

      // reciprocal estimate, low by at most one
      always_ff @(posedge clk_i) begin
        p_b_q[k][l]   <= p_a_q[k][l];
        est_b_q[k][l] <= 32'(pb >> SH);
        sum_b_q[k][l] <= sum_a_q[k][l];
      end

      // correct the quotient
      always_ff @(posedge clk_i) begin
        term_q[k+1][l] <= (rem >= 42'(KDIV)) ? est_b_q[k][l] + 32'd1 : est_b_q[k][l];
        sum_q[k+1][l]  <= sum_b_q[k][l];
      end
    end
  end

  // last term in, then clamp, round and map the quadrant
  logic signed [33:0] sumf_q [2];
  logic [1:0]         quadf_q;

  always_ff @(posedge clk_i) begin
    quadf_q <= ctx_q[NSTEP].quad;
    for (int l = 0; l < 2; l++) begin
      sumf_q[l] <= sum_q[NSTEP][l] + $signed({2'b00, term_q[NSTEP][l]});
    end
  end

  logic [30:0]          v   [2];
  logic [31:0]          rnd [2];
  logic signed [SW-1:0] qs  [2];
  logic signed [SW-1:0] sin_d;
  logic signed [SW-1:0] cos_d;

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      if (sumf_q[l] < 0) begin
        v[l] = '0;
      end else if (sumf_q[l] > 34'sh0_4000_0000) begin
        v[l] = 31'h4000_0000;
      end else begin
        v[l] = sumf_q[l][30:0];
      end
      rnd[l] = 32'(v[l]) + (32'd1 << (29 - FRAC_BITS));
      qs[l]  = $signed({1'b0, QW'(rnd[l] >> (30 - FRAC_BITS))});
    end
    unique case (quadf_q)
      QUAD_0: begin
        sin_d = qs[0];
        cos_d = qs[1];
      end
      QUAD_1: begin
        sin_d = qs[1];
        cos_d = -qs[0];
      end
      QUAD_2: begin
        sin_d = -qs[0];
        cos_d = -qs[1];
      end
      QUAD_3: begin
        sin_d = -qs[1];
        cos_d = qs[0];
      end
      default: begin
        sin_d = qs[0];
        cos_d = qs[1];
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    sin_o <= sin_d;
    cos_o <= cos_d;
  end

endmodule

`default_nettype wire

/* hdl/erm_matrix.sv */
// pipelined zyx rotation matrix products, sums and output rounding
`timescale 1ns / 1ps
`default_nettype none

module erm_matrix #(
  parameter int FRAC_BITS = 14
) (
  input  logic                               clk_i,
  input  logic signed [FRAC_BITS+1:0]        sx_i,
  input  logic signed [FRAC_BITS+1:0]        cx_i,
  input  logic signed [FRAC_BITS+1:0]        sy_i,
  input  logic signed [FRAC_BITS+1:0]        cy_i,
  input  logic signed [FRAC_BITS+1:0]        sz_i,
  input  logic signed [FRAC_BITS+1:0]        cz_i,
  output logic signed [erm_pkg::OUT_W-1:0]   r00_o,
  output logic signed [erm_pkg::OUT_W-1:0]   r01_o,
  output logic signed [erm_pkg::OUT_W-1:0]   r02_o,
  output logic signed [erm_pkg::OUT_W-1:0]   r10_o,
  output logic signed [erm_pkg::OUT_W-1:0]   r11_o,
  output logic signed [erm_pkg::OUT_W-1:0]   r12_o,
  output logic signed [erm_pkg::OUT_W-1:0]   r20_o,
  output logic signed [erm_pkg::OUT_W-1:0]   r21_o,
  output logic signed [erm_pkg::OUT_W-1:0]   r22_o
);
  import erm_pkg::*;

  localparam int SW = FRAC_BITS + 2;
  localparam int PW = 2 * FRAC_BITS + 4;
  localparam int TW = 3 * FRAC_BITS + 6;
  localparam int D  = 3 * FRAC_BITS - OUT_FRAC;

  function automatic logic signed [OUT_W-1:0] to_out(input logic signed [TW-1:0] t);
    logic [TW-1:0] m;
    logic [TW-1:0] r;
    m = t[TW-1] ? TW'(-t) : TW'(t);
    r = (m + (TW'(1) << (D - 1))) >> D;
    if (r > TW'(OUT_MAX)) begin
      r = TW'(OUT_MAX);
    end
    return t[TW-1] ? -OUT_W'(r) : OUT_W'(r);
  endfunction

  // stage 1: pair products
  logic signed [PW-1:0] czcy_q, szcx_q, czsy_q, szsy_q, szsx_q;
  logic signed [PW-1:0] szcy_q, czcx_q, czsx_q, cysx_q, cycx_q;
  logic signed [SW-1:0] sx1_q, cx1_q, sy1_q;

  always_ff @(posedge clk_i) begin
    czcy_q <= PW'(cz_i) * PW'(cy_i);
    szcx_q <= PW'(sz_i) * PW'(cx_i);
    czsy_q <= PW'(cz_i) * PW'(sy_i);
    szsy_q <= PW'(sz_i) * PW'(sy_i);
    szsx_q <= PW'(sz_i) * PW'(sx_i);
    szcy_q <= PW'(sz_i) * PW'(cy_i);
    czcx_q <= PW'(cz_i) * PW'(cx_i);
    czsx_q <= PW'(cz_i) * PW'(sx_i);
    cysx_q <= PW'(cy_i) * PW'(sx_i);
    cycx_q <= PW'(cy_i) * PW'(cx_i);
    sx1_q  <= sx_i;
    cx1_q  <= cx_i;
    sy1_q  <= sy_i;
  end

  // stage 2: triple products and pairs scaled to the common fraction
  logic signed [TW-1:0] e00_q, a01_q, b01_q, a02_q, b02_q, e10_q, a11_q;
  logic signed [TW-1:0] b11_q, a12_q, b12_q, e20_q, e21_q, e22_q;

  always_ff @(posedge clk_i) begin
    e00_q <= TW'(czcy_q) <<< FRAC_BITS;
    a01_q <= TW'(szcx_q) <<< FRAC_BITS;
    b01_q <= TW'(czsy_q) * TW'(sx1_q);
    a02_q <= TW'(czsy_q) * TW'(cx1_q);
    b02_q <= TW'(szsx_q) <<< FRAC_BITS;
    e10_q <= -(TW'(szcy_q) <<< FRAC_BITS);
    a11_q <= TW'(czcx_q) <<< FRAC_BITS;
    b11_q <= TW'(szsy_q) * TW'(sx1_q);
    a12_q <= -(TW'(czsx_q) <<< FRAC_BITS);
    b12_q <= TW'(szsy_q) * TW'(cx1_q);
    e20_q <= -(TW'(sy1_q) <<< (2 * FRAC_BITS));
    e21_q <= TW'(cysx_q) <<< FRAC_BITS;
    e22_q <= TW'(cycx_q) <<< FRAC_BITS;
  end

  // stage 3: sums
  logic signed [TW-1:0] t00_q, t01_q, t02_q, t10_q, t11_q;
  logic signed [TW-1:0] t12_q, t20_q, t21_q, t22_q;

  always_ff @(posedge clk_i) begin
    t00_q <= e00_q;
    t01_q <= a01_q + b01_q;
    t02_q <= a02_q - b02_q;
    t10_q <= e10_q;
    t11_q <= a11_q - b11_q;
    t12_q <= a12_q - b12_q;
    t20_q <= e20_q;
    t21_q <= e21_q;
    t22_q <= e22_q;
  end

  // stage 4: round to q1.14 and saturate
  always_ff @(posedge clk_i) begin
    r00_o <= to_out(t00_q);
    r01_o <= to_out(t01_q);
    r02_o <= to_out(t02_q);
    r10_o <= to_out(t10_q);
    r11_o <= to_out(t11_q);
    r12_o <= to_out(t12_q);
    r20_o <= to_out(t20_q);
    r21_o <= to_out(t21_q);
    r22_o <= to_out(t22_q);
  end

endmodule

`default_nettype wire

/* hdl/euler_rotation_matrix_unit.sv */
// top level of the zyx euler angle rotation matrix unit
// an accepted start reaches the done strobe through the sine and cosine pipelines, then the matrix pipeline
// throughput: one transaction per cycle, busy_o stays low
// the receiver cannot stall, so the pipeline never holds
// reset clears only the valid line, results in flight are dropped
`timescale 1ns / 1ps
`default_nettype none
`include "euler_rotation_matrix_unit_defines.svh"

module euler_rotation_matrix_unit #(
  parameter int ANGLE_BITS = 16,
  parameter int FRAC_BITS  = 14
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  output logic                             busy_o,
  input  logic [erm_pkg::ANG_IN_W-1:0]     angle_x_i,
  input  logic [erm_pkg::ANG_IN_W-1:0]     angle_y_i,
  input  logic [erm_pkg::ANG_IN_W-1:0]     angle_z_i,
  output logic                             done_o,
  output logic signed [erm_pkg::OUT_W-1:0] r00_o,
  output logic signed [erm_pkg::OUT_W-1:0] r01_o,
  output logic signed [erm_pkg::OUT_W-1:0] r02_o,
  output logic signed [erm_pkg::OUT_W-1:0] r10_o,
  output logic signed [erm_pkg::OUT_W-1:0] r11_o,
  output logic signed [erm_pkg::OUT_W-1:0] r12_o,
  output logic signed [erm_pkg::OUT_W-1:0] r20_o,
  output logic signed [erm_pkg::OUT_W-1:0] r21_o,
  output logic signed [erm_pkg::OUT_W-1:0] r22_o
);
  import erm_pkg::*;

  localparam int SW = FRAC_BITS + 2;

  // sine and cosine of each angle, 28 stages each, all in lockstep
  logic signed [SW-1:0] sx, cx, sy, cy, sz, cz;

  erm_sincos #(
    .ANGLE_BITS(ANGLE_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_sc_x (
    .clk_i  (clk_i),
    .angle_i(angle_x_i),
    .sin_o  (sx),
    .cos_o  (cx)
  );

  erm_sincos #(
    .ANGLE_BITS(ANGLE_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_sc_y (
    .clk_i  (clk_i),
    .angle_i(angle_y_i),
    .sin_o  (sy),
    .cos_o  (cy)
  );

  erm_sincos #(
    .ANGLE_BITS(ANGLE_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_sc_z (
    .clk_i  (clk_i),
    .angle_i(angle_z_i),
    .sin_o  (sz),
    .cos_o  (cz)
  );

  // products, sums and rounding, 4 stages
  erm_matrix #(
    .FRAC_BITS(FRAC_BITS)
  ) u_matrix (
    .clk_i(clk_i),
    .sx_i (sx),
    .cx_i (cx),
    .sy_i (sy),
    .cy_i (cy),
    .sz_i (sz),
    .cz_i (cz),
    .r00_o(r00_o),
    .r01_o(r01_o),
    .r02_o(r02_o),
    .r10_o(r10_o),
    .r11_o(r11_o),
    .r12_o(r12_o),
    .r20_o(r20_o),
    .r21_o(r21_o),
    .r22_o(r22_o)
  );

  // valid line alongside the datapath, one bit per stage
  logic [LAT-1:0] vld_q;
  logic [LAT-1:0] vld_d;

  assign vld_d = {vld_q[LAT-2:0], start_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  // no back pressure anywhere, a transaction is taken whenever start is high
  assign busy_o = 1'b0;
  assign done_o = vld_q[LAT-1];

  `ERM_ASSERT(a_start_gives_done, clk_i, rst_ni, start_i |-> ##LAT done_o)
  `ERM_ASSERT(a_no_spurious_done, clk_i, rst_ni, !start_i |-> ##LAT !done_o)
  `ERM_ASSERT_NEVER(a_r00_range, clk_i, rst_ni, done_o && (r00_o > OUT_MAX || r00_o < -OUT_MAX))
  `ERM_ASSERT_NEVER(a_r11_range, clk_i, rst_ni, done_o && (r11_o > OUT_MAX || r11_o < -OUT_MAX))

endmodule

`default_nettype wire

/* sim/tb_euler_rotation_matrix_unit.sv */
// self-checking testbench for the zyx euler angle rotation matrix unit
`timescale 1ns / 1ps

module tb_euler_rotation_matrix_unit;

  localparam int ANGLE_BITS = 16;
  localparam int FRAC_BITS  = 14;
  localparam int CYCLE_LIMIT = 400000;

  typedef logic signed [erm_pkg::OUT_W-1:0] entry_t;
  typedef struct {
    entry_t e [9];
  } matrix_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  logic [15:0] angle_x_i = '0, angle_y_i = '0, angle_z_i = '0;
  logic busy_o, done_o;
  entry_t r00_o, r01_o, r02_o, r10_o, r11_o, r12_o, r20_o, r21_o, r22_o;

  matrix_t matrices_due [$];
  int unsigned fail_count = 0;
  int unsigned cycle_count = 0;

  euler_rotation_matrix_unit #(.ANGLE_BITS(ANGLE_BITS), .FRAC_BITS(FRAC_BITS)) dut (
    .clk_i, .rst_ni, .start_i, .busy_o, .angle_x_i, .angle_y_i, .angle_z_i, .done_o,
    .r00_o, .r01_o, .r02_o, .r10_o, .r11_o, .r12_o, .r20_o, .r21_o, .r22_o
  );

  always #2 clk_i = ~clk_i;

  // truncated taylor series in q30, clamped to [0, 1]
  function automatic longint taylor_q30(longint unsigned first, longint unsigned x2, int n);
    longint unsigned term;
    longint sum;
    term = first;
    sum = longint'(first);
    for (int k = 0; k < 8; k++) begin
      term = ((term * x2) >> 30) / longint'((n + 1) * (n + 2));
      n += 2;
      if (k % 2 == 0) sum -= longint'(term);
      else sum += longint'(term);
    end
    if (sum < 0) sum = 0;
    if (sum > (64'sd1 << 30)) sum = 64'sd1 << 30;
    return sum;
  endfunction

  function automatic longint round_frac(longint v);
    return (v + (64'sd1 << (29 - FRAC_BITS))) >>> (30 - FRAC_BITS);
  endfunction

  // sine and cosine of a binary angle, quadrant folded
  task automatic angle_sin_cos(input logic [15:0] ang, output longint s_o, output longint c_o);
    longint unsigned a, rem, th, x2;
    longint s, c;
    int quad;
    a = longint'(ang) & ((64'd1 << ANGLE_BITS) - 1);
    quad = int'((a >> (ANGLE_BITS - 2)) & 3);
    rem = a & ((64'd1 << (ANGLE_BITS - 2)) - 1);
    th = (rem * 64'd1686629713) >> (ANGLE_BITS - 2);
    x2 = (th * th) >> 30;
    s = round_frac(taylor_q30(th, x2, 1));
    c = round_frac(taylor_q30(64'd1 << 30, x2, 0));
    case (quad)
      0: begin s_o = s; c_o = c; end
      1: begin s_o = c; c_o = -s; end
      2: begin s_o = -s; c_o = -c; end
      default: begin s_o = -c; c_o = s; end
    endcase
  endtask

  // one rounding to q1.14 with ties away from zero, then saturation
  function automatic entry_t to_entry(longint t);
    int d;
    longint m;
    d = 3 * FRAC_BITS - erm_pkg::OUT_FRAC;
    m = (t < 0) ? -t : t;
    m = (m + (64'sd1 << (d - 1))) >>> d;
    if (m > erm_pkg::OUT_MAX) m = erm_pkg::OUT_MAX;
    return entry_t'((t < 0) ? -m : m);
  endfunction

  task automatic rotation_matrix(input logic [15:0] ax, ay, az, output matrix_t m);
    longint sx, cx, sy, cy, sz, cz, one, one2;
    one = 64'sd1 << FRAC_BITS;
    one2 = one * one;
    angle_sin_cos(ax, sx, cx);
    angle_sin_cos(ay, sy, cy);
    angle_sin_cos(az, sz, cz);
    m.e[0] = to_entry(cz * cy * one);
    m.e[1] = to_entry(sz * cx * one + cz * sy * sx);
    m.e[2] = to_entry(cz * sy * cx - sz * sx * one);
    m.e[3] = to_entry(-(sz * cy * one));
    m.e[4] = to_entry(cz * cx * one - sz * sy * sx);
    m.e[5] = to_entry(-(cz * sx * one) - sz * sy * cx);
    m.e[6] = to_entry(-(sy * one2));
    m.e[7] = to_entry(cy * sx * one);
    m.e[8] = to_entry(cy * cx * one);
  endtask

  // mostly short gaps, a few long ones, many back to back
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // one transaction: start held until accepted, prediction queued at acceptance
  task automatic send_angles(input logic [15:0] ax, ay, az, input int gap);
    matrix_t m;
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i <= 1'b1;
    angle_x_i <= ax;
    angle_y_i <= ay;
    angle_z_i <= az;
    do @(posedge clk_i); while (busy_o);
    rotation_matrix(ax, ay, az, m);
    matrices_due.push_back(m);
  endtask

  // drop start for one cycle at least
  task automatic stop_sending();
    start_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // result checker, samples on the edge that ends the strobe cycle
  always @(posedge clk_i) begin
    matrix_t want;
    entry_t got [9];
    string names [9];
    names = '{"r00", "r01", "r02", "r10", "r11", "r12", "r20", "r21", "r22"};
    got = '{r00_o, r01_o, r02_o, r10_o, r11_o, r12_o, r20_o, r21_o, r22_o};
    if (rst_ni && done_o) begin
      if (matrices_due.size() == 0) begin
        $error("result with no transaction outstanding");
        fail_count++;
      end else begin
        want = matrices_due.pop_front();
        for (int i = 0; i < 9; i++)
          if (got[i] !== want.e[i]) begin
            $error("%s expected %0d actual %0d", names[i], want.e[i], got[i]);
            fail_count++;
          end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // angle extremes, quadrant boundaries and neighbours on every axis
  task automatic test_directed();
    logic [15:0] marks [8];
    marks = '{16'h0000, 16'h0001, 16'h3FFF, 16'h4000, 16'h7FFF, 16'h8000, 16'hC000, 16'hFFFF};
    foreach (marks[i]) send_angles(marks[i], 16'h0000, 16'h0000, 0);
    foreach (marks[i]) send_angles(16'h0000, marks[i], 16'h0000, gap_len());
    foreach (marks[i]) send_angles(16'h0000, 16'h0000, marks[i], gap_len());
    send_angles(16'h2000, 16'h2000, 16'h2000, 0);
    send_angles(16'hFFFF, 16'hFFFF, 16'hFFFF, 0);
    send_angles(16'h4000, 16'h4000, 16'h4000, 0);
    send_angles(16'h0000, 16'h0000, 16'hC000, 0);
    send_angles(16'h5555, 16'hAAAA, 16'h5555, 0);
    stop_sending();
  endtask

  // random angles, some pinned near quadrant edges where quantisation may saturate
  task automatic test_random(input int count);
    logic [15:0] a [3];
    for (int n = 0; n < count; n++) begin
      foreach (a[i]) begin
        if ($urandom_range(0, 4) == 0)
          a[i] = {2'($urandom), 14'($urandom_range(0, 3) == 0 ? 0 : 16383 - $urandom_range(0, 3))};
        else
          a[i] = 16'($urandom);
      end
      send_angles(a[0], a[1], a[2], gap_len());
      if ($urandom_range(0, 200) == 0) stop_sending();
    end
    stop_sending();
  endtask

  initial begin
    int wait_count;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random(1130);
    wait_count = 0;
    while (matrices_due.size() != 0 && wait_count < 2000) begin
      @(posedge clk_i);
      wait_count++;
    end
    repeat (erm_pkg::LAT + 8) @(posedge clk_i);
    if (fail_count == 0 && matrices_due.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      if (matrices_due.size() != 0) $error("%0d results never arrived", matrices_due.size());
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
